/* hw/rtl/half_float_converter_assert.svh */
// Assertion macros used by the converter module
`ifndef HALF_FLOAT_CONVERTER_ASSERT_SVH
`define HALF_FLOAT_CONVERTER_ASSERT_SVH
`ifndef SYNTHESIS
`define HFC_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HFC_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HFC_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define HFC_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

/* hw/rtl/hfc_pkg.sv */
package hfc_pkg;
    localparam int unsigned OperandW = 32;
    localparam logic CmdPack   = 1'b0;
    localparam logic CmdUnpack = 1'b1;
    localparam logic [7:0] BiasDiff = 8'd112;

    typedef struct packed {
        logic                cmd;
        logic [OperandW-1:0] operand;
    } t_in_item;

    typedef struct packed {
        logic [OperandW-1:0] result;
        logic                overflowed;
    } t_out_item;

    // Decoded fields after stage 1
    typedef struct packed {
        logic        cmd;
        logic        sign;
        logic [7:0]  exp8;
        logic [22:0] man;
        // pack classes
        logic        p_zero;
        logic        p_sub;
        logic        p_special;
        logic [3:0]  p_shift;
        // unpack classes
        logic [3:0]  u_lz;
        logic        u_zero;
        logic        u_sub;
        logic        u_special;
    } t_dec;
endpackage

/* hw/rtl/hfc_stream_if.sv */
interface hfc_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/hfc_decode.sv */
module hfc_decode
    import hfc_pkg::*;
(
    input  t_in_item i_item,
    output t_dec     o_dec
);
    logic [7:0] e8;
    logic [9:0] hm;
    logic [3:0] lz;

    assign e8 = i_item.operand[30:23];
    assign hm = i_item.operand[9:0];

    // leading zero count of half significand
    always_comb begin
        lz = 4'd10;
        for (int i = 0; i < 10; i++) begin
            if (hm[i]) lz = 4'(9 - i);
        end
    end

    always_comb begin
        o_dec.cmd       = i_item.cmd;
        o_dec.sign      = (i_item.cmd == CmdPack) ? i_item.operand[31] : i_item.operand[15];
        o_dec.exp8      = e8;
        o_dec.man       = (i_item.cmd == CmdPack) ? i_item.operand[22:0]
                                                  : {i_item.operand[14:10], 8'd0, hm};
        // single exp < 102 flushes, 102..112 go subnormal
        o_dec.p_zero    = e8 < 8'd102;
        o_dec.p_sub     = (e8 >= 8'd102) && (e8 <= BiasDiff);
        o_dec.p_special = e8 == 8'hff;
        o_dec.p_shift   = 4'(8'd113 - e8);
        o_dec.u_lz      = lz;
        o_dec.u_zero    = (i_item.operand[14:10] == 5'd0) && (hm == 10'd0);
        o_dec.u_sub     = (i_item.operand[14:10] == 5'd0) && (hm != 10'd0);
        o_dec.u_special = i_item.operand[14:10] == 5'h1f;
    end
endmodule

/* hw/rtl/hfc_round.sv */
module hfc_round
    import hfc_pkg::*;
(
    input  t_dec      i_dec,
    output t_out_item o_item
);
    logic [23:0] sm;
    logic [23:0] rm;
    logic [9:0]  hman;
    logic [5:0]  he;
    logic [10:0] nrm;
    logic [9:0]  un_m;
    logic [7:0]  un_e;
    logic [4:0]  hexp;

    always_comb begin
        sm   = 24'(({1'b1, i_dec.man}) >> i_dec.p_shift);
        rm   = sm + (sm[12] ? 24'h2000 : 24'h0);
        hman = i_dec.man[22:13];
        he   = 6'(i_dec.exp8 - BiasDiff);
        nrm  = {1'b0, i_dec.man[22:13]} + {10'd0, i_dec.man[12]};
        hexp = i_dec.man[22:18];
        un_m = 10'(i_dec.man[9:0] << (i_dec.u_lz + 4'd1));
        un_e = BiasDiff - {4'd0, i_dec.u_lz};
        o_item = '0;
        if (i_dec.cmd == CmdPack) begin
            if (i_dec.p_zero) begin
                o_item.result = {16'd0, i_dec.sign, 15'd0};
            end else if (i_dec.p_sub) begin
                o_item.result = {16'd0, i_dec.sign, 15'(rm >> 13)};
            end else if (i_dec.p_special) begin
                o_item.result = {16'd0, i_dec.sign, 5'h1f,
                                 hman | {9'd0, i_dec.man != 23'd0 && hman == 10'd0}};
            end else if (i_dec.exp8 > 8'd142 || (he == 6'd30 && nrm[10])) begin
                o_item.result     = {16'd0, i_dec.sign, 5'h1f, 10'd0};
                o_item.overflowed = 1'b1;
            end else begin
                o_item.result = {16'd0, i_dec.sign, 5'(he + {5'd0, nrm[10]}), nrm[9:0]};
            end
        end else begin
            if (i_dec.u_zero) begin
                o_item.result = {i_dec.sign, 31'd0};
            end else if (i_dec.u_sub) begin
                o_item.result = {i_dec.sign, un_e, un_m, 13'd0};
            end else if (i_dec.u_special) begin
                o_item.result = {i_dec.sign, 8'hff, i_dec.man[9:0], 13'd0};
            end else begin
                o_item.result = {i_dec.sign, 8'({3'd0, hexp} + BiasDiff),
                                 i_dec.man[9:0], 13'd0};
            end
        end
    end
endmodule

/* hw/rtl/half_float_converter.sv */
// Half/single float converter.
// Input channel i_in carries cmd and operand: cmd 0 packs a single to a half
// (half in result[15:0], upper bits zero), cmd 1 unpacks operand[15:0] to a
// single. Output channel o_out carries result and overflowed, set when a
// finite single rounds to half infinity.
// Both are valid/ready channels; a transfer occurs when both are high.
// Pipeline: input register, decode stage, round/assemble stage; an item is
// registered in each of them in that order, and output valid comes from the
// round/assemble register; throughput is one item per cycle while not stalled.
// Each stage advances when the stage after it is empty or moving, so a
// stalled receiver holds all data in place; nothing is lost or repeated.
// Synchronous active-low reset clears all valid bits; payload is not reset.
`include "half_float_converter_assert.svh"
module half_float_converter
    import hfc_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    hfc_stream_if.sink   i_in,
    hfc_stream_if.source o_out
);
    logic      r_v0, r_v1, r_v2;
    t_in_item  r_d0;
    t_dec      r_d1, n_d1;
    t_out_item r_d2, n_d2;
    logic      adv0, adv1, adv2;

    assign adv2 = !r_v2 || o_out.ready;
    assign adv1 = !r_v1 || adv2;
    assign adv0 = !r_v0 || adv1;
    assign i_in.ready = adv0;

    hfc_decode u_dec (.i_item(r_d0), .o_dec(n_d1));
    hfc_round  u_rnd (.i_dec(r_d1), .o_item(n_d2));

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv0) r_v0 <= i_in.valid;
            if (adv1) r_v1 <= r_v0;
            if (adv2) r_v2 <= r_v1;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (adv0) r_d0 <= i_in.data;
        if (adv1) r_d1 <= n_d1;
        if (adv2) r_d2 <= n_d2;
    end

    assign o_out.valid = r_v2;
    assign o_out.data  = r_d2;

    `HFC_ASSERT_IMPL(a_hold, i_clk, i_rst_n, (r_v2 && !o_out.ready) |=> (r_v2 && $stable(r_d2)), "held output changed")
    `HFC_ASSERT_IMPL(a_unpack_noovf, i_clk, i_rst_n, (r_v1 && r_d1.cmd == CmdUnpack) |-> !n_d2.overflowed, "unpack overflow")
    `HFC_ASSERT_IMPL(a_pack_upper, i_clk, i_rst_n, (r_v1 && r_d1.cmd == CmdPack) |-> (n_d2.result[31:16] == 16'd0), "pack upper bits")
    `HFC_ASSERT_NORST(a_rst, i_clk, !i_rst_n |=> !o_out.valid, "valid after reset")
endmodule
